// ===== hdl/assert_macros.svh =====
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");
// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ===== hdl/afc_pkg.sv =====
package afc_pkg;

    // default widths
    localparam int COORD_BITS_DEF       = 16;
    localparam int NORMAL_FRAC_BITS_DEF = 14;

    // plane register layout
    localparam int PLANE_COUNT = 6;
    localparam int AXIS_COUNT  = 3;
    localparam int NORMAL_W    = 16;
    localparam int DIST_W      = 16;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 64;

    // plane register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PLANE_LEFT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PLANE_RIGHT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PLANE_TOP    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PLANE_BOTTOM = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PLANE_NEAR   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PLANE_FAR    = 3'd5;

    // classification codes
    localparam int VIS_W = 2;
    typedef enum logic [VIS_W-1:0] {
        VIS_INSIDE    = 2'd0,
        VIS_INTERSECT = 2'd1,
        VIS_OUTSIDE   = 2'd2
    } t_vis;

endpackage

// ===== hdl/aabb_frustum_classifier_unit.sv =====
// path: an accepted request passes stages 1 to 5 before its result is on o_visibility
// throughput: one box per cycle unless stalled, set by the five-stage compute pipeline
//   (center/extent add, 36 products, plane sums, compares, classification)
// reset: synchronous active low; clears all six planes to zero and empties the pipeline
// config writes are taken every cycle (o_cfg_ready is always high)
module aabb_frustum_classifier_unit #(
    parameter int COORD_BITS       = afc_pkg::COORD_BITS_DEF,
    parameter int NORMAL_FRAC_BITS = afc_pkg::NORMAL_FRAC_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration write channel
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [afc_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [afc_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    // box request channel
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic signed [COORD_BITS-1:0]        i_min_x,
    input  logic signed [COORD_BITS-1:0]        i_min_y,
    input  logic signed [COORD_BITS-1:0]        i_min_z,
    input  logic signed [COORD_BITS-1:0]        i_max_x,
    input  logic signed [COORD_BITS-1:0]        i_max_y,
    input  logic signed [COORD_BITS-1:0]        i_max_z,
    input  logic signed [COORD_BITS-1:0]        i_pos_x,
    input  logic signed [COORD_BITS-1:0]        i_pos_y,
    input  logic signed [COORD_BITS-1:0]        i_pos_z,
    // result channel
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [afc_pkg::VIS_W-1:0]           o_visibility
);
    import afc_pkg::*;
    `include "assert_macros.svh"

    // doubled center and doubled half extent
    localparam int C2_W  = COORD_BITS + 2;
    localparam int H2_W  = COORD_BITS + 1;
    localparam int ABS_W = NORMAL_W + 1;
    localparam int PD_W  = C2_W + NORMAL_W;
    localparam int PR_W  = H2_W + ABS_W;
    localparam int SUM_A = COORD_BITS + 22;
    localparam int SUM_B = NORMAL_FRAC_BITS + 20;
    localparam int SUM_W = (SUM_A > SUM_B) ? SUM_A : SUM_B;

    // plane registers
    logic [CFG_DATA_W-1:0] r_plane [PLANE_COUNT];

    // stage valids and advance chain
    logic r_v1, r_v2, r_v3, r_v4, r_v5;
    logic w_adv1, w_adv2, w_adv3, w_adv4, w_adv5;

    // stage 1 payload
    logic signed [C2_W-1:0] r_c2 [AXIS_COUNT];
    logic signed [H2_W-1:0] r_h2 [AXIS_COUNT];
    logic signed [C2_W-1:0] n_c2 [AXIS_COUNT];
    logic signed [H2_W-1:0] n_h2 [AXIS_COUNT];

    // stage 2 payload
    logic signed [PD_W-1:0] r_pd [PLANE_COUNT][AXIS_COUNT];
    logic signed [PR_W-1:0] r_pr [PLANE_COUNT][AXIS_COUNT];
    logic signed [PD_W-1:0] n_pd [PLANE_COUNT][AXIS_COUNT];
    logic signed [PR_W-1:0] n_pr [PLANE_COUNT][AXIS_COUNT];

    // stage 3 payload
    logic signed [SUM_W-1:0] r_dist [PLANE_COUNT];
    logic signed [SUM_W-1:0] r_rad  [PLANE_COUNT];
    logic signed [SUM_W-1:0] r_lim  [PLANE_COUNT];
    logic signed [SUM_W-1:0] n_dist [PLANE_COUNT];
    logic signed [SUM_W-1:0] n_rad  [PLANE_COUNT];
    logic signed [SUM_W-1:0] n_lim  [PLANE_COUNT];

    // stage 4 payload
    logic [PLANE_COUNT-1:0] r_out_flags, n_out_flags;
    logic [PLANE_COUNT-1:0] r_int_flags, n_int_flags;

    // stage 5 output register
    t_vis r_vis, n_vis;

    // config port never blocks
    assign o_cfg_ready = 1'b1;

    // plane register writes, indexes past the last plane are dropped
    always_ff @(posedge i_clk) begin
        for (int p = 0; p < PLANE_COUNT; p++) begin
            if (!i_rst_n) begin
                r_plane[p] <= '0;
            end else if (i_cfg_valid && o_cfg_ready && (i_cfg_index == CFG_IDX_W'(p))) begin
                r_plane[p] <= i_cfg_data;
            end
        end
    end

    // a stage moves when it is empty or the next one moves
    assign w_adv5  = !r_v5 || !i_stall;
    assign w_adv4  = !r_v4 || w_adv5;
    assign w_adv3  = !r_v3 || w_adv4;
    assign w_adv2  = !r_v2 || w_adv3;
    assign w_adv1  = !r_v1 || w_adv2;
    assign o_stall = !w_adv1;

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (w_adv1) r_v1 <= i_valid;
            if (w_adv2) r_v2 <= r_v1;
            if (w_adv3) r_v3 <= r_v2;
            if (w_adv4) r_v4 <= r_v3;
            if (w_adv5) r_v5 <= r_v4;
        end
    end

    // stage 1: doubled center and doubled half extent per axis
    always_comb begin
        n_c2[0] = C2_W'(i_max_x) + C2_W'(i_min_x) + (C2_W'(i_pos_x) <<< 1);
        n_c2[1] = C2_W'(i_max_y) + C2_W'(i_min_y) + (C2_W'(i_pos_y) <<< 1);
        n_c2[2] = C2_W'(i_max_z) + C2_W'(i_min_z) + (C2_W'(i_pos_z) <<< 1);
        n_h2[0] = H2_W'(i_max_x) - H2_W'(i_min_x);
        n_h2[1] = H2_W'(i_max_y) - H2_W'(i_min_y);
        n_h2[2] = H2_W'(i_max_z) - H2_W'(i_min_z);
    end

    always_ff @(posedge i_clk) begin
        if (w_adv1) begin
            r_c2 <= n_c2;
            r_h2 <= n_h2;
        end
    end

    // stage 2: center times normal and extent times abs normal, per plane and axis
    always_comb begin
        logic signed [NORMAL_W-1:0] nrm;
        logic signed [ABS_W-1:0]    nrm_w;
        logic signed [ABS_W-1:0]    nrm_abs;
        for (int p = 0; p < PLANE_COUNT; p++) begin
            for (int a = 0; a < AXIS_COUNT; a++) begin
                nrm       = r_plane[p][NORMAL_W*a +: NORMAL_W];
                nrm_w     = ABS_W'(nrm);
                nrm_abs   = (nrm_w < 0) ? -nrm_w : nrm_w;
                n_pd[p][a] = PD_W'(r_c2[a]) * PD_W'(nrm);
                n_pr[p][a] = PR_W'(r_h2[a]) * PR_W'(nrm_abs);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv2) begin
            r_pd <= n_pd;
            r_pr <= n_pr;
        end
    end

    // stage 3: plane distance, radius and the aligned limit -d
    always_comb begin
        logic signed [DIST_W-1:0] dp;
        for (int p = 0; p < PLANE_COUNT; p++) begin
            dp        = r_plane[p][NORMAL_W*AXIS_COUNT +: DIST_W];
            n_dist[p] = SUM_W'(r_pd[p][0]) + SUM_W'(r_pd[p][1]) + SUM_W'(r_pd[p][2]);
            n_rad[p]  = SUM_W'(r_pr[p][0]) + SUM_W'(r_pr[p][1]) + SUM_W'(r_pr[p][2]);
            n_lim[p]  = -(SUM_W'(dp) <<< (NORMAL_FRAC_BITS + 1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv3) begin
            r_dist <= n_dist;
            r_rad  <= n_rad;
            r_lim  <= n_lim;
        end
    end

    // stage 4: per-plane outside and intersect tests
    always_comb begin
        for (int p = 0; p < PLANE_COUNT; p++) begin
            n_out_flags[p] = (r_dist[p] + r_rad[p]) < r_lim[p];
            n_int_flags[p] = (r_dist[p] - r_rad[p]) < r_lim[p];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv4) begin
            r_out_flags <= n_out_flags;
            r_int_flags <= n_int_flags;
        end
    end

    // stage 5: any outside plane wins, then any intersecting plane
    always_comb begin
        if (|r_out_flags) begin
            n_vis = VIS_OUTSIDE;
        end else if (|r_int_flags) begin
            n_vis = VIS_INTERSECT;
        end else begin
            n_vis = VIS_INSIDE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv5) begin
            r_vis <= n_vis;
        end
    end

    assign o_valid      = r_v5;
    assign o_visibility = r_vis;

    // checks
    `ASSERT_IMPLIES(a_stall_only_when_full, i_clk, i_rst_n, o_stall, o_valid && i_stall)
    `ASSERT_IMPLIES(a_vis_code_legal, i_clk, i_rst_n, o_valid, o_visibility != 2'd3)
    `ASSERT_NEXT(a_left_plane_write, i_clk, i_rst_n,
        i_cfg_valid && o_cfg_ready && (i_cfg_index == REG_PLANE_LEFT),
        r_plane[REG_PLANE_LEFT] == $past(i_cfg_data))
    `ASSERT_NEXT(a_no_hit_is_inside, i_clk, i_rst_n,
        r_v4 && w_adv5 && (r_out_flags == '0) && (r_int_flags == '0),
        o_valid && (o_visibility == VIS_INSIDE))
    `ASSERT_NEXT(a_any_out_is_outside, i_clk, i_rst_n,
        r_v4 && w_adv5 && (r_out_flags != '0),
        o_valid && (o_visibility == VIS_OUTSIDE))

endmodule
